/* rtl/core/slwg_pkg.sv */
// Package for the serpentine lane waypoint generator.
// Holds the controller state codes, register indexes, status codes and constants.
// No dependencies.
`default_nettype none
package slwg_pkg;

  localparam int unsigned MAX_LANES = 32;
  localparam int unsigned LANE_W    = $clog2(MAX_LANES);

  localparam logic [15:0] OVL_FULL  = 16'd10000;
  localparam logic [15:0] OVL_CAP   = 16'd9900;

  // ceil(2^44 / 10000). Multiplying by it and dropping 44 bits gives the exact
  // quotient by 10000 for every dividend below 2^30.
  localparam logic [31:0] RECIP_10K   = 32'd1759218605;
  localparam int unsigned RECIP_SHIFT = 44;

  typedef enum logic [2:0] {
    CFG_FIELD_MIN_X = 3'd0,
    CFG_FIELD_MAX_X = 3'd1,
    CFG_FIELD_MIN_Y = 3'd2,
    CFG_FIELD_MAX_Y = 3'd3,
    CFG_SPRAY_WIDTH = 3'd4,
    CFG_OVERLAP     = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_LANES = 2'd2
  } status_t;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHECK = 11'b00000000010,
    S_MUL   = 11'b00000000100,
    S_DIV   = 11'b00000001000,
    S_LANES = 11'b00000010000,
    S_SQA   = 11'b00000100000,
    S_SQB   = 11'b00001000000,
    S_ISQ   = 11'b00010000000,
    S_EMT   = 11'b00100000000,
    S_EMS   = 11'b01000000000,
    S_EME   = 11'b10000000000
  } state_t;

endpackage : slwg_pkg
`default_nettype wire

/* rtl/core/serpentine_lane_waypoint_generator.sv */
// Serpentine lane waypoint generator: clamps a rectangle and emits a lane path.
// One sequencer drives a shared multiplier (also used as a reciprocal divide by
// 10000 for the pitch) and an integer square root step. Depends on slwg_pkg.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | rectangle, reference point, tag
//   out_    | output    | out_valid / out_ready | one waypoint or one error result
//   cfg_    | input     | cfg_we                | register index and data
//
// Setup: S_CHECK, S_MUL, S_DIV, then an S_LANES step per lane counted (up to 32).
// Each transit waypoint takes two squares and 32 root steps of work.
// rst_n is synchronous; reset restores register defaults and the idle state.
// in_ready is high only while idle; a stalled output holds the sequencer.
`default_nettype none
module serpentine_lane_waypoint_generator (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [31:0]    in_rect_min_x,
  input  wire logic signed [31:0]    in_rect_max_x,
  input  wire logic signed [31:0]    in_rect_min_y,
  input  wire logic signed [31:0]    in_rect_max_y,
  input  wire logic signed [31:0]    in_ref_x,
  input  wire logic signed [31:0]    in_ref_y,
  input  wire logic [15:0]           in_tag,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [31:0]         out_way_x,
  output logic signed [31:0]         out_way_y,
  output logic                       out_action,
  output logic [15:0]                out_tag_out,
  output logic [31:0]                out_segment_length,
  output logic [31:0]                out_spray_length,
  output slwg_pkg::status_t          out_status,
  output logic                       out_last,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [31:0]           cfg_data
);
  import slwg_pkg::*;

  logic signed [31:0] fminx_r, fmaxx_r, fminy_r, fmaxy_r;
  logic [15:0] width_r, ovl_r;

  state_t state_r, state_nxt;

  logic signed [31:0] xlo_r, xhi_r, ylo_r, yhi_r, refx_r, px_r, py_r;
  logic [15:0] tag_r;
  logic        left_r;
  logic [29:0] rem_div_r;
  logic [15:0] pitch_r;
  logic [20:0] acc_r;
  logic [4:0]  cnt_r;
  logic [LANE_W-1:0] lane_r, last_lane_r;
  logic signed [33:0] ly_acc_r;
  logic [63:0] prod_r;
  logic        ovf_r;
  logic [63:0] rem_r;
  logic [63:0] res_r;

  function automatic logic signed [31:0] clampv(logic signed [31:0] v,
                                                logic signed [31:0] lo,
                                                logic signed [31:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [31:0] adiff(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    return d[32] ? 32'(-d) : d[31:0];
  endfunction

  // Lane geometry for the current lane.
  logic signed [31:0] ly, wa, wb, start_x, other_x;
  logic [31:0] dx, dy;
  always_comb begin
    ly      = (ly_acc_r > 34'(yhi_r)) ? yhi_r : ly_acc_r[31:0];
    start_x = left_r ? xlo_r : xhi_r;
    other_x = left_r ? xhi_r : xlo_r;
    wa      = lane_r[0] ? other_x : start_x;
    wb      = lane_r[0] ? start_x : other_x;
    dx      = adiff(px_r, wa);
    dy      = adiff(py_r, ly);
  end

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    mul_a = dx;
    mul_b = dx;
    if (state_r == S_MUL) begin
      mul_a = {16'd0, width_r};
      mul_b = {16'd0, OVL_FULL - ((ovl_r >= OVL_FULL) ? OVL_CAP : ovl_r)};
    end else if (state_r == S_DIV) begin
      mul_a = {2'b00, rem_div_r};
      mul_b = RECIP_10K;
    end else if (state_r == S_SQB) begin
      mul_a = dy;
      mul_b = dy;
    end
    mul_p = mul_a * mul_b;
  end

  // Entry side from the truncated midpoint.
  logic signed [32:0] msum, mid;
  always_comb begin
    msum = 33'(xlo_r) + 33'(xhi_r);
    mid  = (msum >>> 1) + 33'((msum[32] && msum[0]) ? 1 : 0);
  end

  logic [15:0] quo;
  assign quo = mul_p[RECIP_SHIFT +: 16];

  // Square root step.
  logic [63:0] sbit, strial;
  logic        sge;
  always_comb begin
    sbit   = 64'd1 << {cnt_r, 1'b0};
    strial = res_r + sbit;
    sge    = rem_r >= strial;
  end

  logic out_xfer;
  assign out_xfer = out_valid && out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMT) || (state_r == S_EMS) || (state_r == S_EME);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CHECK;
      S_CHECK: state_nxt = (xlo_r >= xhi_r || ylo_r > yhi_r) ? S_EME : S_MUL;
      S_MUL:   state_nxt = S_DIV;
      S_DIV:   state_nxt = S_LANES;
      S_LANES: begin
        if (32'(acc_r) >= 32'(yhi_r - ylo_r)) state_nxt = S_SQA;
        else if (cnt_r == 5'(MAX_LANES - 1)) state_nxt = S_EME;
      end
      S_SQA:   state_nxt = S_SQB;
      S_SQB:   state_nxt = S_ISQ;
      S_ISQ:   if (cnt_r == 5'd0) state_nxt = S_EMT;
      S_EMT:   if (out_ready) state_nxt = S_EMS;
      S_EMS:   if (out_ready) state_nxt = (lane_r == last_lane_r) ? S_IDLE : S_SQA;
      S_EME:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fminx_r <= 32'sd0;
      fmaxx_r <= 32'sd1000;
      fminy_r <= 32'sd0;
      fmaxy_r <= 32'sd1000;
      width_r <= 16'd1000;
      ovl_r   <= 16'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FIELD_MIN_X: fminx_r <= cfg_data;
          CFG_FIELD_MAX_X: fmaxx_r <= cfg_data;
          CFG_FIELD_MIN_Y: fminy_r <= cfg_data;
          CFG_FIELD_MAX_Y: fmaxy_r <= cfg_data;
          CFG_SPRAY_WIDTH: width_r <= cfg_data[15:0];
          CFG_OVERLAP:     ovl_r   <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        xlo_r  <= clampv(in_rect_min_x, fminx_r, fmaxx_r);
        xhi_r  <= clampv(in_rect_max_x, fminx_r, fmaxx_r);
        ylo_r  <= clampv(in_rect_min_y, fminy_r, fmaxy_r);
        yhi_r  <= clampv(in_rect_max_y, fminy_r, fmaxy_r);
        refx_r <= in_ref_x;
        px_r   <= in_ref_x;
        py_r   <= in_ref_y;
        tag_r  <= in_tag;
      end
      S_CHECK: begin
        left_r <= (33'(refx_r) <= mid);
        out_way_x          <= 32'sd0;
        out_way_y          <= 32'sd0;
        out_action         <= 1'b0;
        out_tag_out        <= tag_r;
        out_segment_length <= 32'd0;
        out_spray_length   <= 32'd0;
        out_status         <= ST_EMPTY;
        out_last           <= 1'b1;
      end
      S_MUL: begin
        rem_div_r <= mul_p[29:0];
      end
      S_DIV: begin
        pitch_r <= (quo == 16'd0) ? 16'd1 : quo;
        acc_r   <= 21'd0;
        cnt_r   <= 5'd0;
      end
      S_LANES: begin
        acc_r       <= acc_r + 21'(pitch_r);
        cnt_r       <= cnt_r + 5'd1;
        last_lane_r <= cnt_r[LANE_W-1:0];
        lane_r      <= '0;
        ly_acc_r    <= 34'(ylo_r);
        out_status  <= ST_LANES;
      end
      S_SQA: prod_r <= mul_p;
      S_SQB: begin
        {ovf_r, rem_r} <= 65'(prod_r) + 65'(mul_p);
        res_r <= 64'd0;
        cnt_r <= 5'd31;
      end
      S_ISQ: begin
        if (sge) begin
          rem_r <= rem_r - strial;
          res_r <= (res_r >> 1) + sbit;
        end else begin
          res_r <= res_r >> 1;
        end
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          out_way_x          <= wa;
          out_way_y          <= ly;
          out_action         <= 1'b0;
          out_tag_out        <= tag_r;
          out_segment_length <= ovf_r ? 32'hFFFF_FFFF :
                                (sge ? 32'((res_r >> 1) + sbit) : 32'(res_r >> 1));
          out_spray_length   <= 32'd0;
          out_status         <= ST_OK;
          out_last           <= 1'b0;
        end
      end
      S_EMT: begin
        if (out_xfer) begin
          out_way_x          <= wb;
          out_action         <= 1'b1;
          out_segment_length <= adiff(wa, wb);
          out_spray_length   <= adiff(wa, wb);
          out_last           <= (lane_r == last_lane_r);
        end
      end
      S_EMS: begin
        if (out_xfer) begin
          px_r     <= wb;
          py_r     <= ly;
          lane_r   <= lane_r + 1'b1;
          ly_acc_r <= ly_acc_r + 34'(pitch_r);
        end
      end
      default: ;
    endcase
  end

  // A result is never offered while a new item can be taken.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
    else $error("output offered while idle");
  // Error results always close their rectangle.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && out_status != ST_OK) |-> out_last)
    else $error("error result without last");
  // Spray waypoints only belong to good rectangles.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && out_action) |-> (out_status == ST_OK))
    else $error("spray waypoint with error status");
  // A transit waypoint is always followed by its spray waypoint.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && out_ready && !out_action && out_status == ST_OK)
                   |=> (out_valid && out_action))
    else $error("transit not followed by spray");

endmodule : serpentine_lane_waypoint_generator
`default_nettype wire

/* tb/serpentine_lane_waypoint_generator_tb.sv */
// Self-checking testbench for serpentine_lane_waypoint_generator.
// Predicts every waypoint of each accepted rectangle and checks the result stream
// in order, under random idling on both sides. Depends on slwg_pkg and the RTL.
module serpentine_lane_waypoint_generator_tb;
  import slwg_pkg::*;

  localparam int          IDLE_LIMIT  = 20000;
  localparam int          HOLD_CYCLES = 3000;
  localparam logic [2:0]  CFG_SPARE_6 = 3'd6;
  localparam logic [2:0]  CFG_SPARE_7 = 3'd7;
  localparam logic        ACT_TRANSIT = 1'b0;
  localparam logic        ACT_SPRAY   = 1'b1;

  typedef struct {
    logic signed [31:0] way_x;
    logic signed [31:0] way_y;
    logic               action;
    logic [15:0]        tag;
    logic [31:0]        seg;
    logic [31:0]        spray;
    status_t            status;
    logic               last;
  } exp_point_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] in_rect_min_x, in_rect_max_x, in_rect_min_y, in_rect_max_y;
  logic signed [31:0] in_ref_x, in_ref_y;
  logic [15:0] in_tag;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_way_x, out_way_y;
  logic out_action;
  logic [15:0] out_tag_out;
  logic [31:0] out_segment_length, out_spray_length;
  status_t out_status;
  logic out_last;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  // Shadow copy of the configuration registers.
  logic signed [31:0] fld_min_x, fld_max_x, fld_min_y, fld_max_y;
  logic [15:0] swath_w, overlap;

  exp_point_t expected_waypoints[$];
  int errors;
  int idle_cycles;
  bit no_idle;
  bit hold_req;

  serpentine_lane_waypoint_generator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_rect_min_x(in_rect_min_x), .in_rect_max_x(in_rect_max_x),
    .in_rect_min_y(in_rect_min_y), .in_rect_max_y(in_rect_max_y),
    .in_ref_x(in_ref_x), .in_ref_y(in_ref_y), .in_tag(in_tag),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_way_x(out_way_x), .out_way_y(out_way_y), .out_action(out_action),
    .out_tag_out(out_tag_out), .out_segment_length(out_segment_length),
    .out_spray_length(out_spray_length), .out_status(out_status), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint unsigned dist_abs(longint a, longint b);
    return (a >= b) ? longint'(a - b) : longint'(b - a);
  endfunction

  // Floor square root, one result bit per step from the top.
  function automatic logic [31:0] floor_root(logic [63:0] n);
    logic [31:0] r;
    logic [31:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if ({32'd0, t} * {32'd0, t} <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] segment_len(longint x0, longint y0, longint x1, longint y1);
    logic [63:0] dx;
    logic [63:0] dy;
    logic [64:0] sum;
    dx = dist_abs(x0, x1);
    dy = dist_abs(y0, y1);
    if (dx > 64'hFFFF_FFFF || dy > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
    sum = {1'b0, dx * dx} + {1'b0, dy * dy};
    if (sum[64]) return 32'hFFFF_FFFF;
    return floor_root(sum[63:0]);
  endfunction

  // Appends the whole path (or the single error result) for one rectangle.
  task automatic plan_path(logic signed [31:0] rminx, logic signed [31:0] rmaxx,
                           logic signed [31:0] rminy, logic signed [31:0] rmaxy,
                           logic signed [31:0] refx, logic signed [31:0] refy,
                           logic [15:0] tag);
    longint xlo, xhi, ylo, yhi, pitch, height, lanes, ovl, start_x, other_x;
    longint px, py, ly, a, b;
    exp_point_t w;
    xlo = clamp_to(rminx, fld_min_x, fld_max_x);
    xhi = clamp_to(rmaxx, fld_min_x, fld_max_x);
    ylo = clamp_to(rminy, fld_min_y, fld_max_y);
    yhi = clamp_to(rmaxy, fld_min_y, fld_max_y);
    w.way_x = '0; w.way_y = '0; w.action = ACT_TRANSIT; w.tag = tag;
    w.seg = '0; w.spray = '0; w.last = 1'b1;
    if (xlo >= xhi || ylo > yhi) begin
      w.status = ST_EMPTY;
      expected_waypoints.push_back(w);
      return;
    end
    ovl = (overlap >= OVL_FULL) ? longint'(OVL_CAP) : longint'(overlap);
    pitch = (longint'(swath_w) * (10000 - ovl)) / 10000;
    if (pitch == 0) pitch = 1;
    height = yhi - ylo;
    lanes = (height + pitch - 1) / pitch + 1;
    if (lanes > MAX_LANES) begin
      w.status = ST_LANES;
      expected_waypoints.push_back(w);
      return;
    end
    if (longint'(refx) <= (xlo + xhi) / 2) begin
      start_x = xlo; other_x = xhi;
    end else begin
      start_x = xhi; other_x = xlo;
    end
    px = refx;
    py = refy;
    w.status = ST_OK;
    for (longint i = 0; i < lanes; i++) begin
      ly = ylo + i * pitch;
      if (ly > yhi) ly = yhi;
      a = i[0] ? other_x : start_x;
      b = i[0] ? start_x : other_x;
      w.way_x = 32'(a); w.way_y = 32'(ly); w.action = ACT_TRANSIT;
      w.seg = segment_len(px, py, a, ly); w.spray = '0; w.last = 1'b0;
      expected_waypoints.push_back(w);
      w.way_x = 32'(b); w.action = ACT_SPRAY;
      w.seg = segment_len(a, ly, b, ly); w.spray = 32'(dist_abs(a, b));
      w.last = (i + 1 == lanes);
      expected_waypoints.push_back(w);
      px = b;
      py = ly;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (time %0t)", what, got, want, $time);
    errors++;
  endtask

  // Result checker: every transfer on the output is compared with the oldest prediction.
  always @(posedge clk) begin
    exp_point_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_waypoints.size() == 0) begin
        $display("unexpected waypoint x=%0d y=%0d (time %0t)", out_way_x, out_way_y, $time);
        errors++;
      end else begin
        w = expected_waypoints.pop_front();
        if (out_way_x !== w.way_x) report_mismatch("way_x", out_way_x, w.way_x);
        if (out_way_y !== w.way_y) report_mismatch("way_y", out_way_y, w.way_y);
        if (out_action !== w.action) report_mismatch("action", out_action, w.action);
        if (out_tag_out !== w.tag) report_mismatch("tag_out", out_tag_out, w.tag);
        if (out_segment_length !== w.seg)
          report_mismatch("segment_length", out_segment_length, w.seg);
        if (out_spray_length !== w.spray)
          report_mismatch("spray_length", out_spray_length, w.spray);
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
        if (out_last !== w.last) report_mismatch("last", out_last, w.last);
      end
    end
  end

  // Watchdog on cycles without any transfer or register write.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("serpentine_lane_waypoint_generator_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: mostly ready, short and occasional long stalls, plus a requested long hold.
  initial begin
    int r;
    int len;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (no_idle || r < 70) begin
        out_ready = 1'b1;
      end else begin
        len = (r < 96) ? $urandom_range(1, 3) : $urandom_range(20, 80);
        out_ready = 1'b0;
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      CFG_FIELD_MIN_X: fld_min_x = data;
      CFG_FIELD_MAX_X: fld_max_x = data;
      CFG_FIELD_MIN_Y: fld_min_y = data;
      CFG_FIELD_MAX_Y: fld_max_y = data;
      CFG_SPRAY_WIDTH: swath_w = data[15:0];
      CFG_OVERLAP:     overlap = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_waypoints.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(logic signed [31:0] x0, logic signed [31:0] x1,
                            logic signed [31:0] y0, logic signed [31:0] y1,
                            logic [15:0] w, logic [15:0] ovl);
    wait_drained();
    write_reg(CFG_FIELD_MIN_X, x0);
    write_reg(CFG_FIELD_MAX_X, x1);
    write_reg(CFG_FIELD_MIN_Y, y0);
    write_reg(CFG_FIELD_MAX_Y, y1);
    write_reg(CFG_SPRAY_WIDTH, {16'd0, w});
    write_reg(CFG_OVERLAP, {16'd0, ovl});
  endtask

  // Offers one rectangle and returns at the falling edge after its transfer.
  task automatic send_rect(logic signed [31:0] rminx, logic signed [31:0] rmaxx,
                           logic signed [31:0] rminy, logic signed [31:0] rmaxy,
                           logic signed [31:0] refx, logic signed [31:0] refy,
                           logic [15:0] tag);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    gap = (no_idle || r < 60) ? 0 : (r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_rect_min_x = rminx; in_rect_max_x = rmaxx;
    in_rect_min_y = rminy; in_rect_max_y = rmaxy;
    in_ref_x = refx; in_ref_y = refy; in_tag = tag;
    do @(posedge clk); while (!in_ready);
    plan_path(rminx, rmaxx, rminy, rmaxy, refx, refy, tag);
    @(negedge clk);
    // The item has been taken; nothing is offered until the next call.
    in_valid = 1'b0;
  endtask

  task automatic stop_sending();
    in_valid = 1'b0;
  endtask

  // Value somewhere around the span [lo, hi], sometimes just outside it.
  function automatic logic signed [31:0] pick_near(longint lo, longint hi);
    longint span;
    longint v;
    span = hi - lo;
    if (span < 0) span = -span;
    v = lo - span / 8 + longint'($urandom) % (span + span / 4 + 1);
    return 32'(clamp_to(v, -64'sd2147483648, 64'sd2147483647));
  endfunction

  task automatic test_default_paths();
    no_idle = 1'b1;
    send_rect(100, 900, 0, 1000, -50, -50, 16'h0000);
    send_rect(100, 900, 0, 1000, 2000, 0, 16'hFFFF);
    send_rect(100, 900, 100, 100, 500, 7, 16'h1234);    // ref exactly at the midpoint
    send_rect(100, 900, 100, 100, 501, 7, 16'h1235);
    send_rect(-32'sd2147483648, 32'sd2147483647, -32'sd2147483648, 32'sd2147483647,
              32'sd2147483647, -32'sd2147483648, 16'hA5A5);
    send_rect(300, 300, 0, 500, 0, 0, 16'h0001);         // zero-width rectangle
    send_rect(0, 500, 600, 400, 0, 0, 16'h0002);         // inverted y range
    send_rect(800, 200, 0, 500, 0, 0, 16'h0003);
    send_rect(2000, 3000, 0, 500, 0, 0, 16'h0004);       // clamps to a single x
    no_idle = 1'b0;
  endtask

  task automatic test_pitch_and_lanes();
    set_config(0, 10000, 0, 10000, 16'd1000, 16'd9950); // overlap below OVL_FULL, not capped
    send_rect(0, 10000, 0, 150, 0, 0, 16'h0010);
    send_rect(0, 10000, 0, 10000, 0, 0, 16'h0011);       // too many lanes
    set_config(0, 10000, 0, 10000, 16'd1000, 16'd10000);
    send_rect(0, 10000, 0, 305, 9000, 50, 16'h0012);     // capped overlap, last lane clamps
    set_config(0, 10000, 0, 10000, 16'd0, 16'hFFFF);
    send_rect(0, 10000, 0, 31, 0, 0, 16'h0013);          // zero width, 32 lanes
    send_rect(0, 10000, 0, 32, 0, 0, 16'h0014);
    set_config(0, 10000, 0, 10000, 16'd1, 16'd0);
    send_rect(5, 6, 40, 45, -7, 3, 16'h0015);
    set_config(-32'sd2147483648, 32'sd2147483647, -32'sd2147483648, 32'sd2147483647,
               16'hFFFF, 16'd0);
    send_rect(-32'sd2147483648, 32'sd2147483647, -32'sd2147483648,
              -32'sd2147483648 + 32'sd200000, 32'sd2147483647, 32'sd2147483647, 16'h0016);
    send_rect(-32'sd2147483648, 32'sd2147483647, 0, 32'sd2147483647, 0, 0, 16'h0017);
    set_config(1000, 0, 500, -500, 16'd100, 16'd0);      // inverted field bounds
    send_rect(200, 800, -100, 100, 0, 0, 16'h0018);
    send_rect(-5000, 5000, -5000, 5000, 0, 0, 16'h0019);
    wait_drained();
    write_reg(CFG_SPARE_6, 32'hFFFF_FFFF);               // unused indexes are ignored
    write_reg(CFG_SPARE_7, 32'h0000_0001);
    send_rect(-5000, 5000, -5000, 5000, 0, 0, 16'h001A);
  endtask

  task automatic test_backpressure();
    set_config(0, 100000, 0, 100000, 16'd2000, 16'd2500);
    wait_drained();
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++)
      send_rect(pick_near(0, 100000), pick_near(0, 100000), pick_near(0, 20000),
                pick_near(0, 20000), $urandom, $urandom, 16'($urandom));
    stop_sending();
  endtask

  task automatic test_random_phases();
    longint x0, y0, xs, ys, pitch;
    logic [15:0] w, ovl;
    logic signed [31:0] a, b, c, d;
    for (int ph = 0; ph < 8; ph++) begin
      w = (ph == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
      ovl = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9999));
      pitch = (longint'(w) * (10000 - ((ovl >= OVL_FULL) ? 9900 : ovl))) / 10000;
      if (pitch == 0) pitch = 1;
      x0 = $signed(32'($urandom)) / 4;
      y0 = $signed(32'($urandom)) / 4;
      xs = (ph == 1) ? 0 : $urandom_range(0, 1 << 28);
      ys = pitch * $urandom_range(0, 12);
      no_idle = (ph == 3);
      set_config(32'(x0), 32'(x0 + xs), 32'(y0), 32'(y0 + ys), w, ovl);
      for (int i = 0; i < 40; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          a = $urandom; b = $urandom; c = $urandom; d = $urandom;
        end else begin
          a = pick_near(x0, x0 + xs); b = pick_near(x0, x0 + xs);
          if (a > b) {a, b} = {b, a};
          c = pick_near(y0, y0 + ys); d = pick_near(y0, y0 + ys);
          if (c > d && $urandom_range(0, 7) != 0) {c, d} = {d, c};
        end
        send_rect(a, b, c, d, ($urandom_range(0, 3) == 0) ? $urandom : pick_near(x0, x0 + xs),
                  $urandom, 16'($urandom));
      end
      stop_sending();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rect_min_x = '0; in_rect_max_x = '0; in_rect_min_y = '0; in_rect_max_y = '0;
    in_ref_x = '0; in_ref_y = '0; in_tag = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    fld_min_x = 0; fld_max_x = 1000; fld_min_y = 0; fld_max_y = 1000;
    swath_w = 16'd1000; overlap = 16'd0;
    errors = 0; idle_cycles = 0; no_idle = 1'b0; hold_req = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_default_paths();
    test_pitch_and_lanes();
    test_backpressure();
    test_random_phases();

    stop_sending();
    while (expected_waypoints.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_waypoints.size() == 0) begin
      $display("serpentine_lane_waypoint_generator_tb OK");
    end else begin
      $display("serpentine_lane_waypoint_generator_tb NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/slwg_pkg.sv
rtl/core/serpentine_lane_waypoint_generator.sv
tb/serpentine_lane_waypoint_generator_tb.sv
